[sv/kiee_pkg.sv]
// Shared types, key codes and control word layout for the keypad expression evaluator.
package kiee_pkg;

	localparam int VAL_W           = 16;
	localparam int KEY_W           = 8;
	localparam int OPC_W           = 2;
	localparam int UPC_W           = 5;
	localparam int STACK_DEPTH_DEF = 4;

	localparam logic [KEY_W-1:0] KEY_ZERO = 8'd48;
	localparam logic [KEY_W-1:0] KEY_NINE = 8'd57;
	localparam logic [KEY_W-1:0] KEY_ADD  = 8'd43;
	localparam logic [KEY_W-1:0] KEY_SUB  = 8'd45;
	localparam logic [KEY_W-1:0] KEY_MUL  = 8'd42;
	localparam logic [KEY_W-1:0] KEY_DIV  = 8'd47;
	localparam logic [KEY_W-1:0] KEY_EVAL = 8'd61;

	// operator codes; bit 1 is the precedence class (1: * and /)
	localparam logic [OPC_W-1:0] OPC_ADD = 2'd0;
	localparam logic [OPC_W-1:0] OPC_SUB = 2'd1;
	localparam logic [OPC_W-1:0] OPC_MUL = 2'd2;
	localparam logic [OPC_W-1:0] OPC_DIV = 2'd3;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_TAKE,
		C_DIGIT,
		C_OP,
		C_EVAL,
		C_OP_DONE,
		C_OPS_EMPTY,
		C_DIV_BUSY,
		C_IS_EVAL,
		C_OUT_FULL
	} cond_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_DIGIT,
		OP_PUSH_ACC,
		OP_POP_ARGS,
		OP_EXEC,
		OP_PUSH_RES,
		OP_PUSH_OP,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		cond_t             cond;
		logic [UPC_W-1:0]  target;
		logic              take;
		dp_op_t            op;
	} ctl_t;

	typedef struct packed {
		logic is_digit;
		logic is_op;
		logic is_eval;
		logic op_done;
		logic ops_empty;
		logic div_busy;
	} stat_t;

	function automatic logic key_is_digit(input logic [KEY_W-1:0] k);
		return (k >= KEY_ZERO) && (k <= KEY_NINE);
	endfunction

	function automatic logic key_is_oper(input logic [KEY_W-1:0] k);
		return (k == KEY_ADD) || (k == KEY_SUB) || (k == KEY_MUL) || (k == KEY_DIV);
	endfunction

	function automatic logic [OPC_W-1:0] key_opc(input logic [KEY_W-1:0] k);
		logic [OPC_W-1:0] c;
		case (k)
			KEY_SUB: c = OPC_SUB;
			KEY_MUL: c = OPC_MUL;
			KEY_DIV: c = OPC_DIV;
			default: c = OPC_ADD;
		endcase
		return c;
	endfunction

endpackage

[sv/keypad_infix_expression_evaluator_top.sv]
// Top level of the keypad infix expression evaluator.
//
//  channel   dir  signals                      content
//  s_*       in   s_tvalid s_tready s_tdata    one key code per item
//  m_*       out  m_tvalid m_tready m_tdata    result of '=' (value)
//                 m_tuser                      division-by-zero flag
//
// Digits, ignored keys, operators and '=' each follow their own microcode
// path; an operator or '=' runs one reduction per operator it pops, and a
// division in a reduction runs on the one-bit-per-cycle divider. At most two
// reductions and one division per item.
// Items are taken one at a time, only at the idle step of the microprogram.
// A waiting result does not block input; only '=' stalls until the output
// register is empty. Reset clears the step counter, counts and flags.
module keypad_infix_expression_evaluator_top
	import kiee_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [KEY_W-1:0] s_tdata,   // [7:0] key_code
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [VAL_W-1:0] m_tdata,   // [15:0] value
	output logic [0:0]       m_tuser    // [0] divide_by_zero
);

	ctl_t             ctl;
	stat_t            stat;
	logic             accept;
	logic             out_wr;
	logic [VAL_W-1:0] out_value;
	logic             out_flag;

	logic             m_tvalid_q;
	logic [VAL_W-1:0] m_tdata_q;
	logic             m_tuser_q;

	// the idle step is the only one that takes an item
	assign s_tready = ctl.take;
	assign accept   = s_tvalid && ctl.take;

	kiee_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.out_full (m_tvalid_q),
		.stat     (stat),
		.ctl      (ctl)
	);

	kiee_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.accept    (accept),
		.key       (s_tdata),
		.stat      (stat),
		.out_wr    (out_wr),
		.out_value (out_value),
		.out_flag  (out_flag)
	);

	// output register; the sequencer only writes it when empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_wr) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_wr) begin
			m_tdata_q <= out_value;
			m_tuser_q <= out_flag;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

	// a result is never written over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_EMIT) |-> !m_tvalid_q)
		else $error("result written while output register full");

	// after taking a key the sequencer leaves the idle step
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken on consecutive cycles");

	// a result only appears after the emit step
	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(ctl.op == OP_EMIT))
		else $error("result appeared without emit step");

endmodule

[sv/kiee_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
module kiee_div
	import kiee_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [VAL_W-1:0] dividend,
	input  logic [VAL_W-1:0] divisor,
	output logic             busy,
	output logic [VAL_W-1:0] quot
);

	localparam int CW = $clog2(VAL_W + 1);

	logic [VAL_W-1:0] rem_q, quo_q, dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [VAL_W:0]   shifted;
	logic [VAL_W+1:0] diff;

	assign shifted = {rem_q, quo_q[VAL_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(VAL_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[VAL_W+1]) begin
				rem_q <= diff[VAL_W-1:0];
				quo_q <= {quo_q[VAL_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[VAL_W-1:0];
				quo_q <= {quo_q[VAL_W-2:0], 1'b0};
			end
		end
	end

	// zero divisor leaves all ones in the quotient
	assign busy = busy_q;
	assign quot = quo_q;

endmodule

[sv/kiee_seq.sv]
// Microcode sequencer: step counter, control store and branch logic.
module kiee_seq
	import kiee_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  logic  out_full,
	input  stat_t stat,
	output ctl_t  ctl
);

	localparam logic [UPC_W-1:0] S_IDLE  = 5'd0;
	localparam logic [UPC_W-1:0] S_D1    = 5'd1;
	localparam logic [UPC_W-1:0] S_D2    = 5'd2;
	localparam logic [UPC_W-1:0] S_D3    = 5'd3;
	localparam logic [UPC_W-1:0] S_IGN   = 5'd4;
	localparam logic [UPC_W-1:0] S_DIGIT = 5'd5;
	localparam logic [UPC_W-1:0] S_O0    = 5'd6;
	localparam logic [UPC_W-1:0] S_O1    = 5'd7;
	localparam logic [UPC_W-1:0] S_OLOOP = 5'd8;
	localparam logic [UPC_W-1:0] S_R0    = 5'd9;
	localparam logic [UPC_W-1:0] S_R1    = 5'd10;
	localparam logic [UPC_W-1:0] S_R2    = 5'd11;
	localparam logic [UPC_W-1:0] S_R3    = 5'd12;
	localparam logic [UPC_W-1:0] S_R4    = 5'd13;
	localparam logic [UPC_W-1:0] S_R5    = 5'd14;
	localparam logic [UPC_W-1:0] S_OPUSH = 5'd15;
	localparam logic [UPC_W-1:0] S_E0    = 5'd16;
	localparam logic [UPC_W-1:0] S_E1    = 5'd17;
	localparam logic [UPC_W-1:0] S_ELOOP = 5'd18;
	localparam logic [UPC_W-1:0] S_EJMP  = 5'd19;
	localparam logic [UPC_W-1:0] S_EWAIT = 5'd20;
	localparam logic [UPC_W-1:0] S_EOUT  = 5'd21;

	function automatic ctl_t cw(input cond_t c, input logic [UPC_W-1:0] t,
		input logic tk, input dp_op_t o);
		ctl_t w;
		w.cond   = c;
		w.target = t;
		w.take   = tk;
		w.op     = o;
		return w;
	endfunction

	function automatic ctl_t ucode(input logic [UPC_W-1:0] a);
		ctl_t w;
		case (a)
			S_IDLE:  w = cw(C_NO_TAKE,   S_IDLE,  1'b1, OP_NONE);
			S_D1:    w = cw(C_DIGIT,     S_DIGIT, 1'b0, OP_NONE);
			S_D2:    w = cw(C_OP,        S_O0,    1'b0, OP_NONE);
			S_D3:    w = cw(C_EVAL,      S_E0,    1'b0, OP_NONE);
			S_IGN:   w = cw(C_ALWAYS,    S_IDLE,  1'b0, OP_NONE);
			S_DIGIT: w = cw(C_ALWAYS,    S_IDLE,  1'b0, OP_DIGIT);
			S_O0:    w = cw(C_NEVER,     S_IDLE,  1'b0, OP_PUSH_ACC);
			S_O1:    w = cw(C_NEVER,     S_IDLE,  1'b0, OP_NONE);
			S_OLOOP: w = cw(C_OP_DONE,   S_OPUSH, 1'b0, OP_NONE);
			S_R0:    w = cw(C_NEVER,     S_IDLE,  1'b0, OP_POP_ARGS);
			S_R1:    w = cw(C_NEVER,     S_IDLE,  1'b0, OP_EXEC);
			S_R2:    w = cw(C_DIV_BUSY,  S_R2,    1'b0, OP_NONE);
			S_R3:    w = cw(C_NEVER,     S_IDLE,  1'b0, OP_PUSH_RES);
			S_R4:    w = cw(C_IS_EVAL,   S_ELOOP, 1'b0, OP_NONE);
			S_R5:    w = cw(C_ALWAYS,    S_OLOOP, 1'b0, OP_NONE);
			S_OPUSH: w = cw(C_ALWAYS,    S_IDLE,  1'b0, OP_PUSH_OP);
			S_E0:    w = cw(C_NEVER,     S_IDLE,  1'b0, OP_PUSH_ACC);
			S_E1:    w = cw(C_NEVER,     S_IDLE,  1'b0, OP_NONE);
			S_ELOOP: w = cw(C_OPS_EMPTY, S_EWAIT, 1'b0, OP_NONE);
			S_EJMP:  w = cw(C_ALWAYS,    S_R0,    1'b0, OP_NONE);
			S_EWAIT: w = cw(C_OUT_FULL,  S_EWAIT, 1'b0, OP_NONE);
			S_EOUT:  w = cw(C_ALWAYS,    S_IDLE,  1'b0, OP_EMIT);
			default: w = cw(C_ALWAYS,    S_IDLE,  1'b0, OP_NONE);
		endcase
		return w;
	endfunction

	logic [UPC_W-1:0] upc_q;
	logic             jmp;

	assign ctl = ucode(upc_q);

	always_comb begin
		case (ctl.cond)
			C_ALWAYS:    jmp = 1'b1;
			C_NO_TAKE:   jmp = !accept;
			C_DIGIT:     jmp = stat.is_digit;
			C_OP:        jmp = stat.is_op;
			C_EVAL:      jmp = stat.is_eval;
			C_OP_DONE:   jmp = stat.op_done;
			C_OPS_EMPTY: jmp = stat.ops_empty;
			C_DIV_BUSY:  jmp = stat.div_busy;
			C_IS_EVAL:   jmp = stat.is_eval;
			C_OUT_FULL:  jmp = out_full;
			default:     jmp = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_IDLE;
		end else begin
			upc_q <= jmp ? ctl.target : upc_q + UPC_W'(1);
		end
	end

endmodule

[sv/kiee_dp.sv]
// Datapath: operand register, value and operator stacks, ALU and divider.
module kiee_dp
	import kiee_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_t             ctl,
	input  logic             accept,
	input  logic [KEY_W-1:0] key,
	output stat_t            stat,
	output logic             out_wr,
	output logic [VAL_W-1:0] out_value,
	output logic             out_flag
);

	localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] acc_q;
	logic [CNT_W-1:0] vcnt_q, ocnt_q;
	logic             err_q;
	logic [VAL_W-1:0] lhs_q, rhs_q, res_q;
	logic [OPC_W-1:0] code_q;

	logic [VAL_W-1:0] vmem [STACK_DEPTH];
	logic [OPC_W-1:0] omem [STACK_DEPTH];
	logic [VAL_W-1:0] rd_a_q, rd_b_q;
	logic [OPC_W-1:0] rd_op_q;

	logic [CNT_W-1:0] vm1, vm2, om1;
	logic             v_room, o_room;
	logic             vwe, owe;
	logic [VAL_W-1:0] vwd, push_val, alu;
	logic [2*VAL_W-1:0] prod;
	logic             div_start, div_busy, div_zero;
	logic [VAL_W-1:0] quot;
	logic [OPC_W-1:0] new_opc;

	assign vm1     = vcnt_q - CNT_W'(1);
	assign vm2     = vcnt_q - CNT_W'(2);
	assign om1     = ocnt_q - CNT_W'(1);
	assign v_room  = vcnt_q < CNT_W'(STACK_DEPTH);
	assign o_room  = ocnt_q < CNT_W'(STACK_DEPTH);
	assign new_opc = key_opc(key_q);

	// reduction result
	assign div_zero = (rhs_q == '0);
	assign push_val = (code_q == OPC_DIV) ? (div_zero ? '1 : quot) : res_q;

	assign vwe = ((ctl.op == OP_PUSH_ACC) || (ctl.op == OP_PUSH_RES)) && v_room;
	assign vwd = (ctl.op == OP_PUSH_ACC) ? acc_q : push_val;
	assign owe = (ctl.op == OP_PUSH_OP) && o_room;

	always_ff @(posedge clk) begin
		if (vwe) begin
			vmem[vcnt_q[AW-1:0]] <= vwd;
		end
		rd_a_q <= vmem[vm1[AW-1:0]];
		rd_b_q <= vmem[vm2[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (owe) begin
			omem[ocnt_q[AW-1:0]] <= new_opc;
		end
		rd_op_q <= omem[om1[AW-1:0]];
	end

	assign prod = lhs_q * rhs_q;
	always_comb begin
		case (code_q)
			OPC_ADD: alu = lhs_q + rhs_q;
			OPC_SUB: alu = lhs_q - rhs_q;
			default: alu = prod[VAL_W-1:0];
		endcase
	end

	assign div_start = (ctl.op == OP_EXEC) && (code_q == OPC_DIV);

	kiee_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (lhs_q),
		.divisor  (rhs_q),
		.busy     (div_busy),
		.quot     (quot)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= key;
		end
		if (ctl.op == OP_POP_ARGS) begin
			code_q <= rd_op_q;
			rhs_q  <= (vcnt_q >= CNT_W'(1)) ? rd_a_q : '0;
			lhs_q  <= (vcnt_q >= CNT_W'(2)) ? rd_b_q : '0;
		end
		if (ctl.op == OP_EXEC) begin
			res_q <= alu;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			vcnt_q <= '0;
			ocnt_q <= '0;
			err_q  <= 1'b0;
		end else begin
			case (ctl.op)
				OP_DIGIT: begin
					// acc*10 + digit; low nibble of '0'..'9' is the digit
					acc_q <= VAL_W'({acc_q, 3'b000}) + VAL_W'({acc_q, 1'b0})
						+ VAL_W'(key_q[3:0]);
				end
				OP_PUSH_ACC: begin
					acc_q <= '0;
					if (v_room) begin
						vcnt_q <= vcnt_q + CNT_W'(1);
					end
				end
				OP_POP_ARGS: begin
					ocnt_q <= om1;
					vcnt_q <= (vcnt_q >= CNT_W'(2)) ? vm2 : '0;
				end
				OP_PUSH_RES: begin
					if (v_room) begin
						vcnt_q <= vcnt_q + CNT_W'(1);
					end
					if ((code_q == OPC_DIV) && div_zero) begin
						err_q <= 1'b1;
					end
				end
				OP_PUSH_OP: begin
					if (o_room) begin
						ocnt_q <= ocnt_q + CNT_W'(1);
					end
				end
				OP_EMIT: begin
					acc_q  <= '0;
					vcnt_q <= '0;
					ocnt_q <= '0;
					err_q  <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// the reduction loop ends when the operator stack is empty or the new operator binds tighter than the top one
	assign stat.is_digit  = key_is_digit(key_q);
	assign stat.is_op     = key_is_oper(key_q);
	assign stat.is_eval   = (key_q == KEY_EVAL);
	assign stat.ops_empty = (ocnt_q == '0);
	assign stat.op_done   = (ocnt_q == '0) || (new_opc[1] && !rd_op_q[1]);
	assign stat.div_busy  = div_busy;

	assign out_wr    = (ctl.op == OP_EMIT);
	assign out_value = (vcnt_q != '0) ? rd_a_q : '0;
	assign out_flag  = err_q;

endmodule

[verif/keypad_infix_expression_evaluator_top_tb.sv]
// Self-checking testbench for the keypad infix expression evaluator top level.
`timescale 1ns / 100ps

module keypad_infix_expression_evaluator_top_tb;
	import kiee_pkg::*;

	localparam int DEPTH       = STACK_DEPTH_DEF;
	localparam int KEY_TARGET  = 1550;   // digits, operators and '=' to take, directed script included
	localparam int CALM_FROM   = 1350;   // no idling on either side past this many keys
	localparam int HOLD_AT     = 300;    // keys taken before the long output hold-off
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN       = 120;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             div0;
	} result_t;

	// one row of the directed script; known rows carry a hand-worked result
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             known;
		logic [VAL_W-1:0] value;
		logic             div0;
	} script_row_t;

	bit               clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [KEY_W-1:0] s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [VAL_W-1:0] m_tdata;
	logic [0:0]       m_tuser;

	// evaluator shadow state
	logic [VAL_W-1:0] acc;
	logic [VAL_W-1:0] vstk [DEPTH];
	logic [OPC_W-1:0] ostk [DEPTH];
	int               stk_n;
	int               ops_n;
	logic             div0_seen;

	result_t          results_due[$];
	int               fails;
	int               keys_taken;
	bit               calm;
	bit               long_hold_done;
	script_row_t      script [25];

	keypad_infix_expression_evaluator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Expression predictor: two stacks, left-associative reduction
	// ---------------------------------------------------------------
	function automatic void push_val(input logic [VAL_W-1:0] v);
		if (stk_n < DEPTH) begin
			vstk[stk_n] = v;
			stk_n++;
		end
	endfunction

	// an empty stack yields zero without touching any entry
	function automatic logic [VAL_W-1:0] pop_val();
		if (stk_n == 0)
			return '0;
		stk_n--;
		return vstk[stk_n];
	endfunction

	function automatic void reduce_top();
		logic [OPC_W-1:0] opc;
		logic [VAL_W-1:0] rhs;
		logic [VAL_W-1:0] lhs;
		logic [VAL_W-1:0] res;
		if (ops_n == 0)
			return;
		ops_n--;
		opc = ostk[ops_n];
		rhs = pop_val();
		lhs = pop_val();
		case (opc)
			OPC_ADD: res = lhs + rhs;
			OPC_SUB: res = lhs - rhs;
			OPC_MUL: res = lhs * rhs;
			default: begin
				if (rhs == '0) begin
					div0_seen = 1'b1;
					res = '1;
				end else begin
					res = lhs / rhs;
				end
			end
		endcase
		push_val(res);
	endfunction

	// returns 1 when the key produces a result
	function automatic bit eval_key(input logic [KEY_W-1:0] k, output result_t r);
		logic [OPC_W-1:0] opc;
		bit               is_op;
		r = '0;
		if (k >= KEY_ZERO && k <= KEY_NINE) begin
			acc = acc * 16'd10 + VAL_W'(k - KEY_ZERO);
			return 1'b0;
		end
		is_op = 1'b1;
		case (k)
			KEY_ADD: opc = OPC_ADD;
			KEY_SUB: opc = OPC_SUB;
			KEY_MUL: opc = OPC_MUL;
			KEY_DIV: opc = OPC_DIV;
			default: begin
				opc = OPC_ADD;
				is_op = 1'b0;
			end
		endcase
		if (is_op) begin
			push_val(acc);
			acc = '0;
			// bit 1 of the code is the precedence class
			while (ops_n > 0 && opc[1] <= ostk[ops_n-1][1])
				reduce_top();
			if (ops_n < DEPTH) begin
				ostk[ops_n] = opc;
				ops_n++;
			end
			return 1'b0;
		end
		if (k == KEY_EVAL) begin
			push_val(acc);
			while (ops_n > 0)
				reduce_top();
			r.value = (stk_n > 0) ? vstk[stk_n-1] : '0;
			r.div0 = div0_seen;
			acc = '0;
			stk_n = 0;
			ops_n = 0;
			div0_seen = 1'b0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// ---------------------------------------------------------------
	// Key sender: drives at the falling edge, one item per handshake
	// ---------------------------------------------------------------
	task automatic put_key(input logic [KEY_W-1:0] k, input logic known = 1'b0,
			input logic [VAL_W-1:0] k_val = '0, input logic k_div0 = 1'b0);
		result_t r;
		bit      has_res;
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= k;
		do
			@(posedge clk);
		while (!s_tready);
		has_res = eval_key(k, r);
		if (has_res) begin
			if (known) begin
				r.value = k_val;
				r.div0  = k_div0;
			end
			results_due.push_back(r);
		end
		if (key_is_digit(k) || key_is_oper(k) || k == KEY_EVAL)
			keys_taken++;
	endtask

	// occasional stray byte ahead of a real key
	task automatic put_key_noisy(input logic [KEY_W-1:0] k);
		if ($urandom_range(0, 19) == 0)
			put_key(KEY_W'($urandom_range(0, 255)));
		put_key(k);
	endtask

	// operand of 0..5 digits; the long ones wrap past 65535
	task automatic put_operand();
		int sel;
		int n_dig;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			n_dig = 0;
		else if (sel <= 5)
			n_dig = 1;
		else if (sel <= 7)
			n_dig = $urandom_range(2, 3);
		else if (sel == 8)
			n_dig = 4;
		else
			n_dig = 5;
		repeat (n_dig)
			put_key_noisy(KEY_ZERO + KEY_W'($urandom_range(0, 9)));
	endtask

	task automatic put_expression();
		int n_ops;
		logic [KEY_W-1:0] ops [4];
		ops = '{KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV};
		n_ops = $urandom_range(0, 4);
		put_operand();
		repeat (n_ops) begin
			put_key_noisy(ops[$urandom_range(0, 3)]);
			put_operand();
		end
		// now and then the expression runs on into the next one
		if ($urandom_range(0, 14) != 0)
			put_key_noisy(KEY_EVAL);
	endtask

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		acc       = '0;
		stk_n     = 0;
		ops_n     = 0;
		div0_seen = 1'b0;
		fails      = 0;
		keys_taken = 0;
		calm       = 1'b0;

		// directed: ignored extremes, empty expression, division by zero,
		// wrapping operand, left associativity, precedence
		script = '{
			'{8'h00,    1'b0, 16'd0,     1'b0},
			'{KEY_EVAL, 1'b1, 16'd0,     1'b0},
			'{"7",      1'b0, 16'd0,     1'b0},
			'{KEY_DIV,  1'b0, 16'd0,     1'b0},
			'{"0",      1'b0, 16'd0,     1'b0},
			'{KEY_EVAL, 1'b1, 16'hFFFF,  1'b1},
			'{8'hFF,    1'b0, 16'd0,     1'b0},
			'{"9",      1'b0, 16'd0,     1'b0},
			'{"9",      1'b0, 16'd0,     1'b0},
			'{"9",      1'b0, 16'd0,     1'b0},
			'{"9",      1'b0, 16'd0,     1'b0},
			'{"9",      1'b0, 16'd0,     1'b0},
			'{KEY_EVAL, 1'b0, 16'd0,     1'b0},
			'{"8",      1'b0, 16'd0,     1'b0},
			'{KEY_SUB,  1'b0, 16'd0,     1'b0},
			'{"3",      1'b0, 16'd0,     1'b0},
			'{KEY_SUB,  1'b0, 16'd0,     1'b0},
			'{"2",      1'b0, 16'd0,     1'b0},
			'{KEY_EVAL, 1'b0, 16'd0,     1'b0},
			'{"2",      1'b0, 16'd0,     1'b0},
			'{KEY_ADD,  1'b0, 16'd0,     1'b0},
			'{"3",      1'b0, 16'd0,     1'b0},
			'{KEY_MUL,  1'b0, 16'd0,     1'b0},
			'{"4",      1'b0, 16'd0,     1'b0},
			'{KEY_EVAL, 1'b0, 16'd0,     1'b0}
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			put_key(script[i].key, script[i].known, script[i].value, script[i].div0);

		// random: mostly well-formed expressions with stray keys mixed in
		while (keys_taken < KEY_TARGET) begin
			if (keys_taken >= CALM_FROM)
				calm = 1'b1;
			if ($urandom_range(0, 9) == 0)
				put_key(KEY_W'($urandom_range(0, 255)));
			else
				put_expression();
		end
		put_key(KEY_EVAL);
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (fails == 0)
			$display("keypad_infix_expression_evaluator_top verification clean");
		else
			$display("keypad_infix_expression_evaluator_top verification failed");
		$finish;
	end

	// ---------------------------------------------------------------
	// Result receiver: random stalls, plus one long hold-off so that a
	// second '=' backs up behind the full output register
	// ---------------------------------------------------------------
	initial begin
		m_tready = 1'b0;
		long_hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!long_hold_done && keys_taken >= HOLD_AT) begin
				long_hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				m_tready <= 1'b1;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// compare each delivered result with the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				$error("unexpected result: value %0d divide_by_zero %0d", m_tdata, m_tuser);
				fails++;
			end else begin
				want = results_due.pop_front();
				if (m_tdata !== want.value) begin
					$error("value: expected %0d, got %0d", want.value, m_tdata);
					fails++;
				end
				if (m_tuser[0] !== want.div0) begin
					$error("divide_by_zero: expected %0d, got %0d", want.div0, m_tuser[0]);
					fails++;
				end
			end
		end
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("keypad_infix_expression_evaluator_top verification failed");
		$finish;
	end

endmodule
